/* hw/rtl/owbm_pkg.sv */
// Shared types and constants of the 1-Wire bus master core.
// Holds request codes, register indexes, reset values and the result record.
// Depends on nothing; every other file of the block imports it.
package owbm_pkg;

    localparam int TIMER_BITS_DEFAULT = 10;
    localparam int BITS_PER_BYTE      = 8;
    localparam int CFG_DATA_BITS      = 10;
    localparam int CFG_INDEX_BITS     = 3;

    // Fixed durations of the reset sequence, in microseconds.
    localparam logic [9:0] SETTLE_US      = 10'd20;
    localparam logic [9:0] SAMPLE_WAIT_US = 10'd50;
    localparam logic [9:0] RESET_RECOV_US = 10'd120;
    localparam logic [9:0] COUNT_MAX      = 10'd1023;

    // Register reset values.
    localparam logic [9:0] PRE_RESET_IDLE_RST   = 10'd100;
    localparam logic [9:0] RESET_LOW_RST        = 10'd560;
    localparam logic [9:0] PRESENCE_WINDOW_RST  = 10'd300;
    localparam logic [9:0] PRESENCE_MIN_LOW_RST = 10'd30;
    localparam logic [7:0] SHORT_LOW_RST        = 8'd5;
    localparam logic [7:0] LONG_LOW_RST         = 8'd80;
    localparam logic [7:0] READ_SAMPLE_RST      = 8'd10;
    localparam logic [7:0] READ_RECOVERY_RST    = 8'd50;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PRE_RESET_IDLE   = 3'd0,
        CFG_RESET_LOW        = 3'd1,
        CFG_PRESENCE_WINDOW  = 3'd2,
        CFG_PRESENCE_MIN_LOW = 3'd3,
        CFG_SHORT_LOW        = 3'd4,
        CFG_LONG_LOW         = 3'd5,
        CFG_READ_SAMPLE      = 3'd6,
        CFG_READ_RECOVERY    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0] pre_reset_idle_us;
        logic [9:0] reset_low_us;
        logic [9:0] presence_window_us;
        logic [9:0] presence_min_low_us;
        logic [7:0] short_low_us;
        logic [7:0] long_low_us;
        logic [7:0] read_sample_us;
        logic [7:0] read_recovery_us;
    } t_cfg;

    typedef struct packed {
        logic [7:0] read_data;
        logic       presence;
        logic       done_res;
        logic       busy_res;
        logic       drive_low;
    } t_result;

endpackage

/* hw/rtl/owbm_cfg.sv */
// Timing register file of the 1-Wire bus master core.
// Depends on owbm_pkg for the register indexes, reset values and t_cfg.
module owbm_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [owbm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [owbm_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    output owbm_pkg::t_cfg                       o_cfg
);
    import owbm_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_reset_idle_us   <= PRE_RESET_IDLE_RST;
            r_cfg.reset_low_us        <= RESET_LOW_RST;
            r_cfg.presence_window_us  <= PRESENCE_WINDOW_RST;
            r_cfg.presence_min_low_us <= PRESENCE_MIN_LOW_RST;
            r_cfg.short_low_us        <= SHORT_LOW_RST;
            r_cfg.long_low_us         <= LONG_LOW_RST;
            r_cfg.read_sample_us      <= READ_SAMPLE_RST;
            r_cfg.read_recovery_us    <= READ_RECOVERY_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PRE_RESET_IDLE:   r_cfg.pre_reset_idle_us   <= i_cfg_wdata;
                CFG_RESET_LOW:        r_cfg.reset_low_us        <= i_cfg_wdata;
                CFG_PRESENCE_WINDOW:  r_cfg.presence_window_us  <= i_cfg_wdata;
                CFG_PRESENCE_MIN_LOW: r_cfg.presence_min_low_us <= i_cfg_wdata;
                CFG_SHORT_LOW:        r_cfg.short_low_us        <= i_cfg_wdata[7:0];
                CFG_LONG_LOW:         r_cfg.long_low_us         <= i_cfg_wdata[7:0];
                CFG_READ_SAMPLE:      r_cfg.read_sample_us      <= i_cfg_wdata[7:0];
                CFG_READ_RECOVERY:    r_cfg.read_recovery_us    <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/owbm_seq.sv */
// Bus sequencer of the 1-Wire bus master core: phase state, timers, shifter.
// Handles one tick or command per valid cycle and presents its result.
// Depends on owbm_pkg for request codes, t_cfg and t_result.
module owbm_seq #(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_operation,
    input  logic [7:0]          i_write_data,
    input  logic                i_line_level,
    input  owbm_pkg::t_cfg      i_cfg,
    output owbm_pkg::t_result   o_result
);
    import owbm_pkg::*;

    localparam int W = (TIMER_BITS > 10) ? TIMER_BITS : 10;
    localparam logic [W-1:0] TMAX_W = W'((2 ** TIMER_BITS) - 1);
    localparam logic [2:0] LAST_BIT = 3'(BITS_PER_BYTE - 1);

    typedef enum logic [3:0] {
        PH_IDLE, PH_R_IDLE, PH_R_LOW, PH_R_SETTLE, PH_R_WINDOW, PH_R_WAIT,
        PH_R_RECOV, PH_W_LOW, PH_W_HIGH, PH_RD_LOW, PH_RD_WAIT, PH_RD_RECOV
    } t_phase;

    // A zero duration counts as one microsecond; long ones clamp to the timer.
    function automatic logic [TIMER_BITS-1:0] dur(input logic [9:0] v);
        logic [W-1:0] vx;
        vx = W'(v);
        if (v == 10'd0) begin
            return TIMER_BITS'(1);
        end else if (vx > TMAX_W) begin
            return TMAX_W[TIMER_BITS-1:0];
        end else begin
            return vx[TIMER_BITS-1:0];
        end
    endfunction

    t_phase                r_phase,   n_phase;
    logic [TIMER_BITS-1:0] r_timer,   n_timer;
    logic [2:0]            r_bit,     n_bit;
    logic [7:0]            r_shift,   n_shift;
    logic [9:0]            r_count,   n_count;
    logic                  r_seen,    n_seen;
    logic                  r_ended,   n_ended;
    logic                  r_presence, n_presence;
    logic                  r_drive,   n_drive;
    logic [7:0]            r_read,    n_read;
    logic                  done;
    logic [TIMER_BITS-1:0] timer_inc;
    logic [TIMER_BITS-1:0] phase_len;

    always_comb begin
        case (r_phase)
            PH_R_IDLE:   phase_len = dur(i_cfg.pre_reset_idle_us);
            PH_R_LOW:    phase_len = dur(i_cfg.reset_low_us);
            PH_R_SETTLE: phase_len = dur(SETTLE_US);
            PH_R_WINDOW: phase_len = dur(i_cfg.presence_window_us);
            PH_R_WAIT:   phase_len = dur(SAMPLE_WAIT_US);
            PH_R_RECOV:  phase_len = dur(RESET_RECOV_US);
            PH_W_LOW:    phase_len = dur({2'b00, r_shift[0] ? i_cfg.short_low_us
                                                            : i_cfg.long_low_us});
            PH_W_HIGH:   phase_len = dur({2'b00, r_shift[0] ? i_cfg.long_low_us
                                                            : i_cfg.short_low_us});
            PH_RD_LOW:   phase_len = dur({2'b00, i_cfg.short_low_us});
            PH_RD_WAIT:  phase_len = dur({2'b00, i_cfg.read_sample_us});
            default:     phase_len = dur({2'b00, i_cfg.read_recovery_us});
        endcase
    end

    assign timer_inc = r_timer + TIMER_BITS'(1);

    always_comb begin
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_count    = r_count;
        n_seen     = r_seen;
        n_ended    = r_ended;
        n_presence = r_presence;
        n_drive    = r_drive;
        n_read     = r_read;
        done       = 1'b0;
        if (i_valid) begin
            if (t_op'(i_operation) == OP_TICK) begin
                if (r_phase != PH_IDLE) begin
                    // The first complete low pulse in the window is measured.
                    if (r_phase == PH_R_WINDOW) begin
                        if (!i_line_level && !r_ended) begin
                            n_seen = 1'b1;
                            if (r_count != COUNT_MAX) begin
                                n_count = r_count + 10'd1;
                            end
                        end else if (i_line_level && r_seen) begin
                            n_ended = 1'b1;
                        end
                    end
                    n_timer = timer_inc;
                    if (timer_inc >= phase_len) begin
                        n_timer = '0;
                        n_drive = 1'b0;
                        case (r_phase)
                            PH_R_IDLE: begin
                                n_phase = PH_R_LOW;
                                n_drive = 1'b1;
                            end
                            PH_R_LOW:    n_phase = PH_R_SETTLE;
                            PH_R_SETTLE: n_phase = PH_R_WINDOW;
                            PH_R_WINDOW: n_phase = PH_R_WAIT;
                            PH_R_WAIT: begin
                                n_presence = r_ended && (r_count > i_cfg.presence_min_low_us)
                                             && i_line_level;
                                n_phase = PH_R_RECOV;
                            end
                            PH_W_LOW:    n_phase = PH_W_HIGH;
                            PH_W_HIGH: begin
                                if (r_bit >= LAST_BIT) begin
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                end else begin
                                    n_bit   = r_bit + 3'd1;
                                    n_shift = {1'b0, r_shift[7:1]};
                                    n_phase = PH_W_LOW;
                                    n_drive = 1'b1;
                                end
                            end
                            PH_RD_LOW:   n_phase = PH_RD_WAIT;
                            PH_RD_WAIT: begin
                                n_shift = {i_line_level, r_shift[7:1]};
                                n_phase = PH_RD_RECOV;
                            end
                            PH_RD_RECOV: begin
                                if (r_bit >= LAST_BIT) begin
                                    n_read  = r_shift;
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                end else begin
                                    n_bit   = r_bit + 3'd1;
                                    n_phase = PH_RD_LOW;
                                    n_drive = 1'b1;
                                end
                            end
                            default: begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end
                        endcase
                    end
                end
            end else if (r_phase == PH_IDLE) begin
                n_bit   = 3'd0;
                n_timer = '0;
                case (t_op'(i_operation))
                    OP_RESET: begin
                        n_count = 10'd0;
                        n_seen  = 1'b0;
                        n_ended = 1'b0;
                        n_phase = PH_R_IDLE;
                        n_drive = 1'b0;
                    end
                    OP_WRITE: begin
                        n_shift = i_write_data;
                        n_phase = PH_W_LOW;
                        n_drive = 1'b1;
                    end
                    default: begin
                        n_shift = 8'd0;
                        n_phase = PH_RD_LOW;
                        n_drive = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_bit      <= 3'd0;
            r_shift    <= 8'd0;
            r_count    <= 10'd0;
            r_seen     <= 1'b0;
            r_ended    <= 1'b0;
            r_presence <= 1'b0;
            r_drive    <= 1'b0;
            r_read     <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_count    <= n_count;
            r_seen     <= n_seen;
            r_ended    <= n_ended;
            r_presence <= n_presence;
            r_drive    <= n_drive;
            r_read     <= n_read;
        end
    end

    assign o_result.drive_low = n_drive;
    assign o_result.busy_res  = (n_phase != PH_IDLE);
    assign o_result.done_res  = done;
    assign o_result.presence  = n_presence;
    assign o_result.read_data = n_read;

endmodule

/* hw/rtl/onewire_bus_master_core.sv */
// Top level of the 1-Wire bus master core: request register, sequencer, result register.
// Depends on owbm_pkg, owbm_cfg and owbm_seq.
//
// Usage. Every request on the slave stream is either a one-microsecond tick, carrying
// the bus level sampled during that microsecond, or a command (bus reset, write byte,
// read byte) given in tuser. Commands are taken only while the sequencer is idle; one
// that arrives while busy is dropped and still yields a result. Each request yields
// exactly one result on the master stream: the line drive for the coming microsecond,
// busy, done, the presence flag and the last byte read.
// A result passes through the request register, which captures the request when it is
// accepted, and the result register, which the sequencer writes when the pipeline
// advances; the result is valid once it sits in the result register.
// A request can be accepted every cycle while the receiver takes results, since the
// sequencer updates its whole state in the cycle it acts on a request.
// When the receiver stalls, the result register holds its value and the request
// register holds one more request; only then does o_s_tready fall. Reset clears both
// pipeline registers, puts the sequencer in idle with the line released, and loads
// the timing registers with their default values. The user must write timing registers
// through the configuration port only while the core is idle; it is not enforced.
module onewire_bus_master_core #(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: write_data [7:0], line_level [8], zero [15:9]
    input  logic [15:0]                          i_s_tdata,
    // tuser: operation [1:0]
    input  logic [1:0]                           i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // tdata: drive_low [0], busy_res [1], done_res [2], presence [3],
    //        read_data [11:4], zero [15:12]
    output logic [15:0]                          o_m_tdata,
    input  logic                                 i_cfg_we,
    input  logic [owbm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [owbm_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);
    import owbm_pkg::*;

    t_cfg       cfg;
    t_result    result;
    logic       advance;
    logic       r_in_valid;
    logic [1:0] r_in_operation;
    logic [7:0] r_in_write_data;
    logic       r_in_line_level;
    logic       r_out_valid;
    t_result    r_out;

    // The pipeline moves whenever the result register is empty or being taken.
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_operation  <= i_s_tuser;
            r_in_write_data <= i_s_tdata[7:0];
            r_in_line_level <= i_s_tdata[8];
        end
    end

    owbm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // The sequencer acts on a request exactly once, in the cycle it leaves the
    // request register for the result register.
    owbm_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid && advance),
        .i_operation  (r_in_operation),
        .i_write_data (r_in_write_data),
        .i_line_level (r_in_line_level),
        .i_cfg        (cfg),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out};

endmodule

/* tb/owbm_tb_pkg.sv */
// Scoreboard for the 1-Wire bus master testbench: a cycle-free model of the sequencer
// and the queue of results it predicts. Depends on owbm_pkg for types and constants.
package owbm_tb_pkg;

    import owbm_pkg::*;

    typedef enum int {
        SEQ_IDLE,
        SEQ_R_IDLE,
        SEQ_R_LOW,
        SEQ_R_SETTLE,
        SEQ_R_WINDOW,
        SEQ_R_WAIT,
        SEQ_R_RECOV,
        SEQ_W_LOW,
        SEQ_W_HIGH,
        SEQ_RD_LOW,
        SEQ_RD_WAIT,
        SEQ_RD_RECOV
    } t_seq_phase;

    class owbm_line_predictor;
        t_cfg        cfg;
        t_seq_phase  phase;
        int unsigned phase_timer;
        int unsigned bit_index;
        logic [7:0]  shift_byte;
        int unsigned low_count;
        bit          pulse_seen;
        bit          pulse_ended;
        bit          presence_flag;
        bit          line_low;
        logic [7:0]  last_read;
        t_result     expected_results[$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            cfg = '{PRE_RESET_IDLE_RST, RESET_LOW_RST, PRESENCE_WINDOW_RST,
                    PRESENCE_MIN_LOW_RST, SHORT_LOW_RST, LONG_LOW_RST,
                    READ_SAMPLE_RST, READ_RECOVERY_RST};
            phase         = SEQ_IDLE;
            phase_timer   = 0;
            bit_index     = 0;
            shift_byte    = '0;
            low_count     = 0;
            pulse_seen    = 1'b0;
            pulse_ended   = 1'b0;
            presence_flag = 1'b0;
            line_low      = 1'b0;
            last_read     = '0;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function bit busy();
            return phase != SEQ_IDLE;
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        function void load_reg(t_cfg_idx idx, logic [9:0] value);
            case (idx)
                CFG_PRE_RESET_IDLE:   cfg.pre_reset_idle_us   = value;
                CFG_RESET_LOW:        cfg.reset_low_us        = value;
                CFG_PRESENCE_WINDOW:  cfg.presence_window_us  = value;
                CFG_PRESENCE_MIN_LOW: cfg.presence_min_low_us = value;
                CFG_SHORT_LOW:        cfg.short_low_us        = value[7:0];
                CFG_LONG_LOW:         cfg.long_low_us         = value[7:0];
                CFG_READ_SAMPLE:      cfg.read_sample_us      = value[7:0];
                default:              cfg.read_recovery_us    = value[7:0];
            endcase
        endfunction

        // A zero duration still lasts one microsecond; the timer width caps the rest.
        function int unsigned span(int unsigned us);
            int unsigned tmax;
            tmax = (1 << TIMER_BITS_DEFAULT) - 1;
            if (us == 0) return 1;
            if (us > tmax) return tmax;
            return us;
        endfunction

        function int unsigned phase_span();
            case (phase)
                SEQ_R_IDLE:   return span(cfg.pre_reset_idle_us);
                SEQ_R_LOW:    return span(cfg.reset_low_us);
                SEQ_R_SETTLE: return span(SETTLE_US);
                SEQ_R_WINDOW: return span(cfg.presence_window_us);
                SEQ_R_WAIT:   return span(SAMPLE_WAIT_US);
                SEQ_R_RECOV:  return span(RESET_RECOV_US);
                SEQ_W_LOW:    return span(shift_byte[0] ? cfg.short_low_us : cfg.long_low_us);
                SEQ_W_HIGH:   return span(shift_byte[0] ? cfg.long_low_us : cfg.short_low_us);
                SEQ_RD_LOW:   return span(cfg.short_low_us);
                SEQ_RD_WAIT:  return span(cfg.read_sample_us);
                default:      return span(cfg.read_recovery_us);
            endcase
        endfunction

        function void enter(t_seq_phase next, bit low);
            phase       = next;
            phase_timer = 0;
            line_low    = low;
        endfunction

        // One microsecond of bus time; returns 1 when the running command completes.
        function bit advance_tick(bit level);
            if (phase == SEQ_IDLE) return 1'b0;
            if (phase == SEQ_R_WINDOW) begin
                if (!level && !pulse_ended) begin
                    pulse_seen = 1'b1;
                    if (low_count < COUNT_MAX) low_count++;
                end else if (level && pulse_seen) begin
                    pulse_ended = 1'b1;
                end
            end
            phase_timer++;
            if (phase_timer < phase_span()) return 1'b0;
            case (phase)
                SEQ_R_IDLE:   enter(SEQ_R_LOW, 1'b1);
                SEQ_R_LOW:    enter(SEQ_R_SETTLE, 1'b0);
                SEQ_R_SETTLE: enter(SEQ_R_WINDOW, 1'b0);
                SEQ_R_WINDOW: enter(SEQ_R_WAIT, 1'b0);
                SEQ_R_WAIT: begin
                    presence_flag = pulse_ended && (low_count > cfg.presence_min_low_us) && level;
                    enter(SEQ_R_RECOV, 1'b0);
                end
                SEQ_W_LOW:    enter(SEQ_W_HIGH, 1'b0);
                SEQ_W_HIGH: begin
                    if (bit_index >= BITS_PER_BYTE - 1) begin
                        enter(SEQ_IDLE, 1'b0);
                        return 1'b1;
                    end
                    bit_index++;
                    shift_byte = shift_byte >> 1;
                    enter(SEQ_W_LOW, 1'b1);
                end
                SEQ_RD_LOW:   enter(SEQ_RD_WAIT, 1'b0);
                SEQ_RD_WAIT: begin
                    shift_byte = {level, shift_byte[7:1]};
                    enter(SEQ_RD_RECOV, 1'b0);
                end
                SEQ_RD_RECOV: begin
                    if (bit_index >= BITS_PER_BYTE - 1) begin
                        last_read = shift_byte;
                        enter(SEQ_IDLE, 1'b0);
                        return 1'b1;
                    end
                    bit_index++;
                    enter(SEQ_RD_LOW, 1'b1);
                end
                default: begin
                    enter(SEQ_IDLE, 1'b0);
                    return 1'b1;
                end
            endcase
            return 1'b0;
        endfunction

        // Notes an accepted request and queues its result. Returns 1 when the
        // request did something, i.e. a tick while busy or a command while idle.
        function bit take_request(t_op op, logic [7:0] data, bit level);
            bit      done;
            bit      effective;
            t_result res;
            done      = 1'b0;
            effective = (op == OP_TICK) ? busy() : !busy();
            if (op == OP_TICK) begin
                done = advance_tick(level);
            end else if (!busy()) begin
                bit_index = 0;
                case (op)
                    OP_RESET: begin
                        low_count   = 0;
                        pulse_seen  = 1'b0;
                        pulse_ended = 1'b0;
                        enter(SEQ_R_IDLE, 1'b0);
                    end
                    OP_WRITE: begin
                        shift_byte = data;
                        enter(SEQ_W_LOW, 1'b1);
                    end
                    default: begin
                        shift_byte = '0;
                        enter(SEQ_RD_LOW, 1'b1);
                    end
                endcase
            end
            res.drive_low = line_low;
            res.busy_res  = busy();
            res.done_res  = done;
            res.presence  = presence_flag;
            res.read_data = last_read;
            expected_results.push_back(res);
            return effective;
        endfunction

        function void compare_result(logic [15:0] tdata);
            t_result got;
            t_result want;
            got = t_result'(tdata[11:0]);
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d (tdata %h) arrived with nothing expected",
                             results_seen, tdata);
                return;
            end
            want = expected_results.pop_front();
            if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res || got.presence !== want.presence ||
                got.read_data !== want.read_data || tdata[15:12] !== 4'd0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d: expected drive %b busy %b done %b %s %b read %h",
                             results_seen, want.drive_low, want.busy_res, want.done_res,
                             "presence", want.presence, want.read_data);
                    $display("       got drive %b busy %b done %b presence %b read %h pad %h",
                             got.drive_low, got.busy_res, got.done_res, got.presence,
                             got.read_data, tdata[15:12]);
                end
            end
        endfunction
    endclass

endpackage

/* tb/tb_onewire_bus_master_core.sv */
// Self-checking testbench of onewire_bus_master_core: directed and random requests,
// each result compared with the scoreboard's prediction. Depends on owbm_pkg and owbm_tb_pkg.
module tb_onewire_bus_master_core;

    timeunit 1ns;
    timeprecision 1ps;

    import owbm_pkg::*;
    import owbm_tb_pkg::*;

    // Counted requests (ticks while busy, commands while idle) wanted in the random part.
    localparam int unsigned RANDOM_ITEMS = 2000;

    // Stall patterns of the result receiver.
    typedef enum int {
        SINK_OPEN,
        SINK_THREE_IN_FOUR,
        SINK_COIN,
        SINK_SPARSE
    } t_sink_mode;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    // tdata: write_data [7:0], line_level [8], zero [15:9]
    logic [15:0] i_s_tdata   = '0;
    // tuser: operation [1:0]
    logic [1:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    // tdata: drive_low [0], busy_res [1], done_res [2], presence [3], read_data [11:4]
    logic [15:0] o_m_tdata;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_wdata = '0;

    owbm_line_predictor bus_model = new();

    // Behaviour of the simulated slave for the command in progress. The line level of
    // each tick is derived from these and from the predicted phase of the sequencer.
    bit          noisy_line;
    bit          sample_high;
    logic [7:0]  slave_byte;
    int unsigned pulse_start;
    int unsigned pulse_len;

    int unsigned burst_left;
    int unsigned counted_items;
    int unsigned commands_started[4];
    int unsigned settings_run;

    onewire_bus_master_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Generous ceiling on the whole run, well above the slowest legal run.
    initial begin
        #10ms;
        $display("Timeout: the core stopped answering, %0d results still expected",
                 bus_model.outstanding());
        $display("FAILED: results differ");
        $finish;
    end

    // The receiver changes its stall pattern at random intervals, so that
    // back-pressure falls on every phase of a command, including long open stretches.
    initial begin : result_sink
        t_sink_mode  mode;
        int unsigned mode_left;
        int unsigned beat;
        mode      = SINK_OPEN;
        mode_left = 0;
        beat      = 0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 400);
            end
            mode_left--;
            beat++;
            case (mode)
                SINK_OPEN:          i_m_tready <= 1'b1;
                SINK_THREE_IN_FOUR: i_m_tready <= (beat % 4) != 3;
                SINK_COIN:          i_m_tready <= 1'($urandom);
                default:            i_m_tready <= (beat % 8) == 0;
            endcase
        end
    end

    // Results are taken at the rising edge, before the core's registers update.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) bus_model.compare_result(o_m_tdata);
    end

    // Presents one request from a falling edge and holds it until it is accepted.
    // The sender works in bursts; between most bursts it drops tvalid.
    // Returns at the falling edge after acceptance with tvalid still high, so the
    // caller either presents the next request at once or drops tvalid itself.
    task automatic send_request(t_op op, logic [7:0] data, bit level);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {7'd0, level, data};
        do @(posedge i_clk); while (!o_s_tready);
        if (bus_model.take_request(op, data, level)) begin
            counted_items++;
            if (op != OP_TICK) commands_started[op]++;
        end
        @(negedge i_clk);
    endtask

    // Holds the sender back until every expected result has come out of the core.
    // It always waits for a falling edge first, so tvalid is never dropped and raised
    // again within the same time step.
    task automatic pause_sender();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (bus_model.outstanding() != 0);
    endtask

    // Writes all eight timing registers, one per cycle. The eight-bit registers also
    // get random upper write-data bits, which the core must discard.
    task automatic program_timing(t_cfg timing);
        logic [9:0] value;
        t_cfg_idx   idx;
        for (int i = 0; i < 8; i++) begin
            idx = t_cfg_idx'(i);
            case (idx)
                CFG_PRE_RESET_IDLE:   value = timing.pre_reset_idle_us;
                CFG_RESET_LOW:        value = timing.reset_low_us;
                CFG_PRESENCE_WINDOW:  value = timing.presence_window_us;
                CFG_PRESENCE_MIN_LOW: value = timing.presence_min_low_us;
                CFG_SHORT_LOW:        value = {2'($urandom), timing.short_low_us};
                CFG_LONG_LOW:         value = {2'($urandom), timing.long_low_us};
                CFG_READ_SAMPLE:      value = {2'($urandom), timing.read_sample_us};
                default:              value = {2'($urandom), timing.read_recovery_us};
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_wdata <= value;
            @(posedge i_clk);
            bus_model.load_reg(idx, value);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic set_slave(int unsigned start, int unsigned len, bit high, logic [7:0] rd);
        noisy_line  = 1'b0;
        pulse_start = start;
        pulse_len   = len;
        sample_high = high;
        slave_byte  = rd;
    endtask

    // Feeds ticks until the sequencer is idle again. The slave answers in the presence
    // window with its pulse, in the last microsecond of the sample wait with its chosen
    // level, and in each read sample with the next bit of its byte; elsewhere the line
    // is mostly high with random dips. Now and then a command arrives while busy.
    task automatic tick_until_idle(int unsigned stray_pct);
        bit level;
        while (bus_model.busy()) begin
            if ($urandom_range(0, 99) < stray_pct) begin
                send_request(t_op'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
            end else begin
                if (noisy_line) begin
                    level = 1'($urandom);
                end else begin
                    case (bus_model.phase)
                        SEQ_R_WINDOW: level = !(bus_model.phase_timer >= pulse_start &&
                                                bus_model.phase_timer < pulse_start + pulse_len);
                        SEQ_R_WAIT:   level = (bus_model.phase_timer == SAMPLE_WAIT_US - 1) ?
                                              sample_high : 1'($urandom);
                        SEQ_RD_WAIT:  level = slave_byte[bus_model.bit_index];
                        default:      level = ($urandom_range(0, 7) != 0);
                    endcase
                end
                send_request(OP_TICK, 8'($urandom), level);
            end
        end
    endtask

    task automatic run_command(t_op op, logic [7:0] data, int unsigned stray_pct);
        send_request(op, data, 1'($urandom));
        tick_until_idle(stray_pct);
    endtask

    initial begin : stimulus
        t_cfg        timing;
        int unsigned win;
        int unsigned stray;

        burst_left    = 0;
        counted_items = 0;
        settings_run  = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default timing straight after reset: a bus reset answered by a slave with a
        // clear presence pulse, then a read.
        set_slave(40, 120, 1'b1, 8'h96);
        run_command(OP_RESET, 8'h00, 0);
        run_command(OP_READ, 8'h00, 0);
        pause_sender();

        // Directed part on fast timing. A short low of zero must behave as one
        // microsecond, and the presence minimum is three, so a four-microsecond pulse
        // is the shortest that counts.
        timing = '{10'd1, 10'd2, 10'd12, 10'd3, 8'd0, 8'd3, 8'd1, 8'd0};
        program_timing(timing);
        send_request(OP_TICK, 8'h00, 1'b0);
        send_request(OP_TICK, 8'hFF, 1'b1);
        run_command(OP_WRITE, 8'hFF, 0);
        run_command(OP_WRITE, 8'h00, 0);
        // Commands arriving in the middle of a write are dropped.
        run_command(OP_WRITE, 8'hA5, 30);
        set_slave(0, 0, 1'b1, 8'h5A);
        run_command(OP_READ, 8'h00, 0);
        set_slave(0, 0, 1'b1, 8'hFF);
        run_command(OP_READ, 8'hFF, 20);
        set_slave(0, 0, 1'b1, 8'h00);
        run_command(OP_READ, 8'h00, 0);
        // Presence: a pulse just long enough, one exactly at the minimum, a good pulse
        // with the line low at the sample, a pulse still low when the window closes,
        // and no slave at all.
        set_slave(2, 4, 1'b1, 8'h00);
        run_command(OP_RESET, 8'h00, 0);
        set_slave(2, 3, 1'b1, 8'h00);
        run_command(OP_RESET, 8'h00, 0);
        set_slave(2, 4, 1'b0, 8'h00);
        run_command(OP_RESET, 8'h00, 0);
        set_slave(2, 12, 1'b1, 8'h00);
        run_command(OP_RESET, 8'h00, 0);
        set_slave(0, 0, 1'b1, 8'h00);
        run_command(OP_RESET, 8'h00, 10);
        pause_sender();

        // All timing registers at zero, then all at their maximum.
        timing = '0;
        program_timing(timing);
        set_slave(0, 1, 1'b1, 8'hC3);
        run_command(OP_RESET, 8'h00, 0);
        run_command(OP_WRITE, 8'h69, 0);
        run_command(OP_READ, 8'h00, 0);
        pause_sender();

        timing = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255, 8'd255};
        program_timing(timing);
        set_slave(1, 1021, 1'b1, 8'h3C);
        run_command(OP_RESET, 8'h00, 0);
        run_command(OP_WRITE, 8'h3C, 5);
        run_command(OP_READ, 8'h00, 0);
        pause_sender();

        // Random part: short timing settings, now and then one register made large,
        // each running a handful of complete commands with random content, mixed with
        // noise of random requests and idle ticks.
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            timing.pre_reset_idle_us   = 10'($urandom_range(0, 6));
            timing.reset_low_us        = 10'($urandom_range(0, 8));
            timing.presence_window_us  = 10'($urandom_range(1, 40));
            timing.presence_min_low_us = 10'($urandom_range(0, 12));
            timing.short_low_us        = 8'($urandom_range(0, 4));
            timing.long_low_us         = 8'($urandom_range(0, 6));
            timing.read_sample_us      = 8'($urandom_range(0, 4));
            timing.read_recovery_us    = 8'($urandom_range(0, 5));
            if ($urandom_range(0, 5) == 0) begin
                case (t_cfg_idx'($urandom_range(0, 7)))
                    CFG_PRE_RESET_IDLE:
                        timing.pre_reset_idle_us = 10'($urandom_range(100, 1023));
                    CFG_RESET_LOW:
                        timing.reset_low_us = 10'($urandom_range(100, 1023));
                    CFG_PRESENCE_WINDOW:
                        timing.presence_window_us = 10'($urandom_range(100, 1023));
                    CFG_PRESENCE_MIN_LOW:
                        timing.presence_min_low_us = 10'($urandom_range(100, 1023));
                    CFG_SHORT_LOW:
                        timing.short_low_us = 8'($urandom_range(60, 255));
                    CFG_LONG_LOW:
                        timing.long_low_us = 8'($urandom_range(60, 255));
                    CFG_READ_SAMPLE:
                        timing.read_sample_us = 8'($urandom_range(60, 255));
                    default:
                        timing.read_recovery_us = 8'($urandom_range(60, 255));
                endcase
            end
            program_timing(timing);
            win = timing.presence_window_us;
            repeat ($urandom_range(3, 12)) begin
                noisy_line  = ($urandom_range(0, 9) == 0);
                sample_high = ($urandom_range(0, 5) != 0);
                slave_byte  = 8'($urandom);
                pulse_start = $urandom_range(0, win / 3);
                case ($urandom_range(0, 3))
                    0:       pulse_len = timing.presence_min_low_us + 1;
                    1:       pulse_len = timing.presence_min_low_us;
                    2:       pulse_len = $urandom_range(1, win);
                    default: pulse_len = 0;
                endcase
                stray = ($urandom_range(0, 3) == 0) ? 5 : 0;
                case ($urandom_range(0, 9))
                    0: begin
                        repeat ($urandom_range(1, 8))
                            send_request(t_op'($urandom_range(0, 3)), 8'($urandom),
                                         1'($urandom));
                        tick_until_idle(stray);
                    end
                    1, 2:    run_command(OP_RESET, 8'($urandom), stray);
                    3, 4, 5: run_command(OP_WRITE, 8'($urandom), stray);
                    6, 7, 8: run_command(OP_READ, 8'($urandom), stray);
                    default: begin
                        repeat ($urandom_range(1, 4))
                            send_request(OP_TICK, 8'($urandom), 1'($urandom));
                    end
                endcase
            end
            pause_sender();
        end

        // Everything has been drained; allow the request and result registers to show any
        // stray result before judging.
        repeat (6) @(negedge i_clk);
        $display("Run covered %0d timing settings with %0d bus resets, %0d writes and %0d reads.",
                 settings_run, commands_started[OP_RESET], commands_started[OP_WRITE],
                 commands_started[OP_READ]);
        $display("%0d results compared, %0d mismatches, %0d results still expected.",
                 bus_model.results_seen, bus_model.mismatches, bus_model.outstanding());
        if (bus_model.mismatches == 0 && bus_model.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
